### rtl/core/hhlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types, codes, byte class lookup and transition function of the HTTP
// header line parser.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int MAX_LINE_DEF = 4096;
  localparam int OFS_OUT_W    = 12;
  localparam int CLASS_W      = 7;
  localparam int TDATA_OUT_W  = 56;

  typedef logic [CLASS_W-1:0] class_t;

  localparam class_t CL_NONE       = 7'd0;
  localparam class_t CL_NAME_LAST  = 7'd38;
  localparam class_t CL_COLON      = 7'd58;
  localparam class_t CL_VALUE_LAST = 7'd67;
  localparam class_t CL_SP         = 7'd68;
  localparam class_t CL_TAB        = 7'd69;
  localparam class_t CL_CR         = 7'd70;
  localparam class_t CL_LF         = 7'd71;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_NAME  = 3'd1,
    ST_SPACE = 3'd2,
    ST_VALUE = 3'd3,
    ST_CR    = 3'd4,
    ST_DONE  = 3'd5,
    ST_BAD   = 3'd6
  } state_t;

  typedef enum logic [1:0] {
    STAT_COMPLETE  = 2'd0,
    STAT_MALFORMED = 2'd1,
    STAT_BAD_BYTE  = 2'd2,
    STAT_BUF_END   = 2'd3
  } status_t;

  function automatic class_t byte_class(input logic [7:0] b);
    class_t c;
    case (b)
      8'h09: c = CL_TAB;
      8'h0A: c = CL_LF;
      8'h0D: c = CL_CR;
      8'h20: c = CL_SP;
      8'h21: c = 7'd39;
      8'h22: c = 7'd60;
      8'h23: c = 7'd40;
      8'h24: c = 7'd41;
      8'h25: c = 7'd42;
      8'h26: c = 7'd43;
      8'h27: c = 7'd44;
      8'h28: c = 7'd51;
      8'h29: c = 7'd52;
      8'h2A: c = 7'd46;
      8'h2B: c = 7'd47;
      8'h2C: c = 7'd56;
      8'h2D: c = 7'd37;
      8'h2E: c = 7'd48;
      8'h2F: c = 7'd61;
      8'h3A: c = CL_COLON;
      8'h3B: c = 7'd57;
      8'h3C: c = 7'd53;
      8'h3D: c = 7'd65;
      8'h3E: c = 7'd54;
      8'h3F: c = 7'd64;
      8'h40: c = 7'd55;
      8'h5B: c = 7'd62;
      8'h5C: c = 7'd59;
      8'h5D: c = 7'd63;
      8'h5E: c = 7'd49;
      8'h5F: c = CL_NAME_LAST;
      8'h60: c = 7'd45;
      8'h7B: c = 7'd66;
      8'h7D: c = CL_VALUE_LAST;
      8'h7E: c = 7'd50;
      default: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          c = 7'(b - 8'h15);
        end else if (b >= 8'h41 && b <= 8'h5A) begin
          c = 7'(b - 8'h40);
        end else if (b >= 8'h61 && b <= 8'h7A) begin
          c = 7'(b - 8'h60);
        end else begin
          c = CL_NONE;
        end
      end
    endcase
    return c;
  endfunction

  function automatic state_t next_state(input state_t st, input class_t cls);
    state_t ns;
    if (st == ST_CR) begin
      ns = (cls == CL_LF) ? ST_DONE : ST_BAD;
    end else if (st == ST_DONE || st == ST_BAD) begin
      ns = ST_BAD;
    end else if (cls == CL_CR) begin
      ns = ST_CR;
    end else if (cls == CL_LF) begin
      ns = ST_DONE;
    end else begin
      case (st)
        ST_START: ns = (cls <= CL_NAME_LAST) ? ST_NAME : ST_BAD;
        ST_NAME: begin
          if (cls <= CL_NAME_LAST) begin
            ns = ST_NAME;
          end else begin
            ns = (cls == CL_COLON) ? ST_SPACE : ST_BAD;
          end
        end
        ST_SPACE: ns = (cls <= CL_VALUE_LAST) ? ST_VALUE : ST_SPACE;
        default:  ns = ST_VALUE;
      endcase
    end
    return ns;
  endfunction

endpackage
`default_nettype wire

### rtl/core/http_header_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_header_line_parser
// Table driven byte parser for one HTTP header line; at most one result beat per line.
// Pipeline: an input beat passes the input register, then class lookup and state
//   update, then the result register.
// Throughput: one byte per cycle while the sink accepts; a result beat held
//   by the sink stalls the input until it drains.
// Reset: the parser waits for a beat with line_start set; both stages empty.
// ----------------------------------------------------------------------------
module http_header_line_parser #(
  parameter int MAX_LINE = hhlp_pkg::MAX_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] line_start
  input  wire logic        s_tlast,   // buffer_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [hhlp_pkg::TDATA_OUT_W-1:0] m_tdata,
  // [11:0] name_start, [12] name_start_valid, [24:13] name_end,
  // [25] name_end_valid, [37:26] value_start, [38] value_start_valid,
  // [50:39] value_end, [51] value_end_valid, [55:52] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int OFS_W = $clog2(MAX_LINE);
  localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_LINE - 1);

  typedef logic [OFS_W-1:0] ofs_t;

  function automatic logic [hhlp_pkg::OFS_OUT_W-1:0] ofs_out(input ofs_t x);
    logic [31:0] w;
    w = 32'(x);
    return w[hhlp_pkg::OFS_OUT_W-1:0];
  endfunction

  // input stage
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_start;
  logic       in_last;
  logic       advance;

  // parser state
  hhlp_pkg::state_t parse_state;
  logic  line_active;
  ofs_t  byte_offset;
  ofs_t  name_start_reg;
  logic  name_start_seen;
  ofs_t  name_end_reg;
  logic  name_end_seen;
  ofs_t  value_start_reg;
  logic  value_start_seen;
  ofs_t  raw_end_reg;
  logic  raw_end_seen;
  ofs_t  last_nonspace;

  // step logic
  logic             act;
  hhlp_pkg::state_t cur_state;
  ofs_t             pos;
  ofs_t             pos_inc;
  hhlp_pkg::class_t cls;
  logic             bad_byte;
  hhlp_pkg::state_t ns;
  hhlp_pkg::state_t parse_state_next;
  ofs_t  name_start_next;
  logic  name_start_seen_next;
  ofs_t  name_end_next;
  logic  name_end_seen_next;
  ofs_t  value_start_next;
  logic  value_start_seen_next;
  ofs_t  raw_end_next;
  logic  raw_end_seen_next;
  ofs_t  last_nonspace_next;
  ofs_t  value_end_next;
  logic  emit;
  hhlp_pkg::status_t status_next;

  // result stage
  logic              out_valid;
  hhlp_pkg::status_t out_status;
  logic [hhlp_pkg::TDATA_OUT_W-1:0] out_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data  <= s_tdata;
      in_start <= s_tuser[0];
      in_last  <= s_tlast;
    end
  end

  always_comb begin
    act       = in_start || line_active;
    cur_state = in_start ? hhlp_pkg::ST_START : parse_state;
    pos       = in_start ? '0 : byte_offset;
    pos_inc   = (pos < OFS_MAX) ? ofs_t'(pos + 1'b1) : pos;
    cls       = hhlp_pkg::byte_class(in_data);
    bad_byte  = (cls == hhlp_pkg::CL_NONE);
    ns        = hhlp_pkg::next_state(cur_state, cls);

    name_start_next       = in_start ? '0 : name_start_reg;
    name_start_seen_next  = in_start ? 1'b0 : name_start_seen;
    name_end_next         = in_start ? '0 : name_end_reg;
    name_end_seen_next    = in_start ? 1'b0 : name_end_seen;
    value_start_next      = in_start ? '0 : value_start_reg;
    value_start_seen_next = in_start ? 1'b0 : value_start_seen;
    raw_end_next          = in_start ? '0 : raw_end_reg;
    raw_end_seen_next     = in_start ? 1'b0 : raw_end_seen;
    last_nonspace_next    = in_start ? '0 : last_nonspace;
    parse_state_next      = cur_state;

    if (!bad_byte) begin
      parse_state_next = ns;
      if (ns != cur_state) begin
        case (ns)
          hhlp_pkg::ST_NAME: begin
            name_start_next      = pos;
            name_start_seen_next = 1'b1;
          end
          hhlp_pkg::ST_SPACE, hhlp_pkg::ST_DONE: begin
            if (!name_end_seen_next) begin
              name_end_next      = pos;
              name_end_seen_next = 1'b1;
            end
            raw_end_next      = pos;
            raw_end_seen_next = 1'b1;
          end
          hhlp_pkg::ST_VALUE: begin
            value_start_next      = pos;
            value_start_seen_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (ns == hhlp_pkg::ST_VALUE && cls != hhlp_pkg::CL_SP && cls != hhlp_pkg::CL_TAB) begin
        last_nonspace_next = pos_inc;
      end
    end

    emit        = 1'b1;
    status_next = hhlp_pkg::STAT_BUF_END;
    if (bad_byte) begin
      status_next = hhlp_pkg::STAT_BAD_BYTE;
    end else if (ns == hhlp_pkg::ST_DONE) begin
      status_next = hhlp_pkg::STAT_COMPLETE;
    end else if (ns == hhlp_pkg::ST_BAD) begin
      status_next = hhlp_pkg::STAT_MALFORMED;
    end else if (!in_last) begin
      emit = 1'b0;
    end

    value_end_next = raw_end_next;
    if (value_start_seen_next && last_nonspace_next < raw_end_next) begin
      value_end_next = last_nonspace_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      parse_state <= hhlp_pkg::ST_START;
    end else if (advance && act) begin
      line_active <= !emit;
      parse_state <= parse_state_next;
    end
    if (advance && act) begin
      byte_offset      <= pos_inc;
      name_start_reg   <= name_start_next;
      name_start_seen  <= name_start_seen_next;
      name_end_reg     <= name_end_next;
      name_end_seen    <= name_end_seen_next;
      value_start_reg  <= value_start_next;
      value_start_seen <= value_start_seen_next;
      raw_end_reg      <= raw_end_next;
      raw_end_seen     <= raw_end_seen_next;
      last_nonspace    <= last_nonspace_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && act && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && act && emit) begin
      out_status <= status_next;
      out_data   <= {4'b0000,
                     raw_end_seen_next, ofs_out(value_end_next),
                     value_start_seen_next, ofs_out(value_start_next),
                     name_end_seen_next, ofs_out(name_end_next),
                     name_start_seen_next, ofs_out(name_start_next)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  a_value_needs_name_end: assert property (@(posedge clk) disable iff (rst)
    line_active && value_start_seen |-> name_end_seen)
    else $error("value start recorded without name end");

  a_open_line_not_ended: assert property (@(posedge clk) disable iff (rst)
    line_active |-> parse_state != hhlp_pkg::ST_DONE && parse_state != hhlp_pkg::ST_BAD)
    else $error("line still open in an end state");

  a_offset_saturates: assert property (@(posedge clk) disable iff (rst)
    line_active |-> byte_offset <= OFS_MAX)
    else $error("byte offset beyond line limit");

  a_complete_has_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == hhlp_pkg::STAT_COMPLETE |-> m_tdata[51] && m_tdata[25])
    else $error("complete line without recorded ends");

endmodule
`default_nettype wire

### dv/http_header_line_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_line_parser_tb
// Self-checking bench for the HTTP header line parser. A short directed set of
// header lines hits the status codes, trimming, empty values, ignored tails
// and dropped lines. Random header lines follow, mostly well formed with
// random content and some corrupted, truncated or noisy.
// A scoreboard predicts the result beat of every line that ends and checks each one
// field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

function automatic hhlp_pkg::class_t http_char_class(input logic [7:0] b);
  string            punct = "-_!#$%&'`*+.^~()<>@,;:\\\"/[]?={}";
  hhlp_pkg::class_t k;
  k = hhlp_pkg::CL_NONE;
  if (b >= 8'h61 && b <= 8'h7A) begin
    k = 7'(b - 8'h60);
  end else if (b >= 8'h41 && b <= 8'h5A) begin
    k = 7'(b - 8'h40);
  end else if (b >= 8'h30 && b <= 8'h39) begin
    k = 7'(b - 8'h30 + 8'd27);
  end else begin
    case (b)
      8'h20: k = hhlp_pkg::CL_SP;
      8'h09: k = hhlp_pkg::CL_TAB;
      8'h0D: k = hhlp_pkg::CL_CR;
      8'h0A: k = hhlp_pkg::CL_LF;
      default: begin
        for (int i = 0; i < punct.len(); i++) begin
          if (punct[i] == b) k = 7'(37 + i);
        end
      end
    endcase
  end
  return k;
endfunction

class hdr_line_scoreboard;
  typedef struct {
    hhlp_pkg::status_t status;
    logic [11:0]       name_start;
    logic              name_start_ok;
    logic [11:0]       name_end;
    logic              name_end_ok;
    logic [11:0]       value_start;
    logic              value_start_ok;
    logic [11:0]       value_end;
    logic              value_end_ok;
  } line_result_t;

  line_result_t     pending_lines[$];
  hhlp_pkg::state_t pstate;
  bit               line_open;
  int               ofs;
  int               nstart, nend, vstart, rawend, trim_end;
  bit               nstart_seen, nend_seen, vstart_seen, rawend_seen;
  int               errors;
  int               lines_checked;
  int               status_count[4];

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 100) begin
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  function hhlp_pkg::state_t advance_state(input hhlp_pkg::state_t s,
                                           input hhlp_pkg::class_t k);
    case (s)
      hhlp_pkg::ST_CR:
        return (k == hhlp_pkg::CL_LF) ? hhlp_pkg::ST_DONE : hhlp_pkg::ST_BAD;
      hhlp_pkg::ST_DONE, hhlp_pkg::ST_BAD: return hhlp_pkg::ST_BAD;
      default: ;
    endcase
    if (k == hhlp_pkg::CL_CR) return hhlp_pkg::ST_CR;
    if (k == hhlp_pkg::CL_LF) return hhlp_pkg::ST_DONE;
    case (s)
      hhlp_pkg::ST_START:
        return (k <= hhlp_pkg::CL_NAME_LAST) ? hhlp_pkg::ST_NAME : hhlp_pkg::ST_BAD;
      hhlp_pkg::ST_NAME: begin
        if (k <= hhlp_pkg::CL_NAME_LAST) return hhlp_pkg::ST_NAME;
        return (k == hhlp_pkg::CL_COLON) ? hhlp_pkg::ST_SPACE : hhlp_pkg::ST_BAD;
      end
      hhlp_pkg::ST_SPACE:
        return (k <= hhlp_pkg::CL_VALUE_LAST) ? hhlp_pkg::ST_VALUE : hhlp_pkg::ST_SPACE;
      default: return hhlp_pkg::ST_VALUE;
    endcase
  endfunction

  function void note_byte(input logic [7:0] b, input logic start, input logic last);
    int                pos;
    int                vend;
    hhlp_pkg::class_t  k;
    hhlp_pkg::state_t  nxt;
    hhlp_pkg::status_t st;
    line_result_t      r;
    if (start) begin
      pstate      = hhlp_pkg::ST_START;
      ofs         = 0;
      nstart      = 0;
      nend        = 0;
      vstart      = 0;
      rawend      = 0;
      trim_end    = 0;
      nstart_seen = 0;
      nend_seen   = 0;
      vstart_seen = 0;
      rawend_seen = 0;
      line_open   = 1;
    end
    if (!line_open) return;
    pos = ofs;
    if (ofs < hhlp_pkg::MAX_LINE_DEF - 1) ofs++;
    k = http_char_class(b);
    if (k == hhlp_pkg::CL_NONE) begin
      st = hhlp_pkg::STAT_BAD_BYTE;
    end else begin
      nxt = advance_state(pstate, k);
      if (nxt != pstate) begin
        case (nxt)
          hhlp_pkg::ST_NAME: begin
            nstart      = pos;
            nstart_seen = 1;
          end
          hhlp_pkg::ST_SPACE, hhlp_pkg::ST_DONE: begin
            if (!nend_seen) begin
              nend      = pos;
              nend_seen = 1;
            end
            rawend      = pos;
            rawend_seen = 1;
          end
          hhlp_pkg::ST_VALUE: begin
            vstart      = pos;
            vstart_seen = 1;
          end
          default: ;
        endcase
      end
      if (nxt == hhlp_pkg::ST_VALUE && k != hhlp_pkg::CL_SP && k != hhlp_pkg::CL_TAB) begin
        trim_end = (pos < hhlp_pkg::MAX_LINE_DEF - 1) ? pos + 1 : pos;
      end
      pstate = nxt;
      if (nxt == hhlp_pkg::ST_DONE) begin
        st = hhlp_pkg::STAT_COMPLETE;
      end else if (nxt == hhlp_pkg::ST_BAD) begin
        st = hhlp_pkg::STAT_MALFORMED;
      end else if (last) begin
        st = hhlp_pkg::STAT_BUF_END;
      end else begin
        return;
      end
    end
    line_open = 0;
    vend = rawend;
    if (vstart_seen && trim_end < vend) vend = trim_end;
    r.status         = st;
    r.name_start     = 12'(nstart);
    r.name_start_ok  = nstart_seen;
    r.name_end       = 12'(nend);
    r.name_end_ok    = nend_seen;
    r.value_start    = 12'(vstart);
    r.value_start_ok = vstart_seen;
    r.value_end      = 12'(vend);
    r.value_end_ok   = rawend_seen;
    pending_lines.push_back(r);
  endfunction

  task check_line(input logic [hhlp_pkg::TDATA_OUT_W-1:0] d, input logic [1:0] u);
    line_result_t e;
    if (pending_lines.size() == 0) begin
      report("result beat with no line pending", {u, d[29:0]}, 0);
      return;
    end
    e = pending_lines.pop_front();
    check_field("status", u, e.status);
    check_field("name_start", d[11:0], e.name_start);
    check_field("name_start_valid", d[12], e.name_start_ok);
    check_field("name_end", d[24:13], e.name_end);
    check_field("name_end_valid", d[25], e.name_end_ok);
    check_field("value_start", d[37:26], e.value_start);
    check_field("value_start_valid", d[38], e.value_start_ok);
    check_field("value_end", d[50:39], e.value_end);
    check_field("value_end_valid", d[51], e.value_end_ok);
    check_field("tdata padding", d[55:52], 0);
    lines_checked++;
    status_count[e.status]++;
  endtask

  task close_out();
    if (pending_lines.size() != 0) report("lines left without result", pending_lines.size(), 0);
  endtask
endclass

module http_header_line_parser_tb;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       last;
  } beat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]                       s_tuser = 1'b0;    // [0] line_start
  logic                             s_tlast = 1'b0;    // buffer_last
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [hhlp_pkg::TDATA_OUT_W-1:0] m_tdata;
  // [11:0] name_start, [12] name_start_valid, [24:13] name_end,
  // [25] name_end_valid, [37:26] value_start, [38] value_start_valid,
  // [50:39] value_end, [51] value_end_valid, [55:52] zero
  logic [1:0]                       m_tuser;           // [1:0] status

  hdr_line_scoreboard sb = new();
  beat_t              stim_q[$];
  int                 stall_left = 0;
  logic [1:0]         stall_mode = 2'd0;

  http_header_line_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic push_beat(input logic [7:0] b, input logic start, input logic last);
    beat_t bt;
    bt.data  = b;
    bt.start = start;
    bt.last  = last;
    stim_q.push_back(bt);
  endtask

  task automatic push_text(input string s, input logic start, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(s[i], start && i == 0, last_at_end && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == 8'h7C);
    return c;
  endfunction

  task automatic push_random_line();
    string      name_chars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
    logic [7:0] q[$];
    int         kind;
    int         cut;
    bit         end_buffer;
    kind       = $urandom_range(0, 99);
    end_buffer = 0;
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) q.push_back(name_chars[$urandom_range(0, 63)]);
      q.push_back(":");
      repeat ($urandom_range(0, 3)) q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 9) == 0) q.push_back(8'h20);
        else q.push_back(value_char());
      end
      repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
      if ($urandom_range(0, 9) < 7) q.push_back(8'h0D);
      q.push_back(8'h0A);
      if (kind >= 72 && kind < 82) begin
        q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 82 && kind < 95) begin
        cut = $urandom_range(1, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
        end_buffer = (kind < 90);
      end else if (kind >= 95) begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (q[i]) begin
      push_beat(q[i], i == 0,
                (end_buffer && i == q.size() - 1) || $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic build_stimulus();
    push_text("zz", 1'b0, 1'b0);
    push_text("Host: example\015\012", 1'b1, 1'b0);
    push_text("A:b\012", 1'b1, 1'b1);
    push_text("Key:  v a l \t\015\012", 1'b1, 1'b0);
    push_text("Accept:\015\012", 1'b1, 1'b0);
    push_text("\015\012", 1'b1, 1'b0);
    push_text("\012", 1'b1, 1'b0);
    push_text(":x\012", 1'b1, 1'b0);
    push_text("ab c:d\012", 1'b1, 1'b0);
    push_text("na", 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_text("me:v\012", 1'b0, 1'b0);
    push_text("X:y", 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b1);
    push_text("ab", 1'b1, 1'b1);
    push_text("a:\015\015", 1'b1, 1'b0);
    push_text("abc", 1'b1, 1'b0);
    push_text("d:e\012", 1'b1, 1'b0);
    push_text("Z-9_:", 1'b1, 1'b1);
    push_text("q:\"{|}\012", 1'b1, 1'b0);
    push_text("x:~`^}\015\012", 1'b1, 1'b0);
    push_text("N: \015x", 1'b1, 1'b0);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b1, 1'b0);
    while (stim_q.size() < 1200) begin
      push_random_line();
    end
  endtask

  task automatic drive_all();
    int burst;
    int gap;
    int i;
    i = 0;
    while (i < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && i < stim_q.size()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= stim_q[i].data;
        s_tuser  <= stim_q[i].start;
        s_tlast  <= stim_q[i].last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(stim_q[i].data, stim_q[i].start, stim_q[i].last);
        i++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 || i == stim_q.size()) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: segments of always-ready, random, sparse and full stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        stall_left <= $urandom_range(4, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_line(m_tdata, m_tuser);
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    drive_all();
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.close_out();
    $display("Drove %0d byte beats, checked %0d header line results", stim_q.size(),
             sb.lines_checked);
    $display("  complete %0d, malformed %0d, bad byte %0d, buffer end %0d",
             sb.status_count[hhlp_pkg::STAT_COMPLETE],
             sb.status_count[hhlp_pkg::STAT_MALFORMED],
             sb.status_count[hhlp_pkg::STAT_BAD_BYTE],
             sb.status_count[hhlp_pkg::STAT_BUF_END]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
